>>> hdl/wakf_pkg.sv
// ----------------------------------------------------------------------------
// wakf_pkg
// Shared types and constants for the wrapped angle Kalman filter.
// ----------------------------------------------------------------------------
package wakf_pkg;

    // request payloads
    typedef struct packed {
        logic signed [15:0] measured_angle;
        logic        [23:0] time_step;
    } wakf_in_t;

    typedef struct packed {
        logic signed [15:0] estimate_angle;
        logic        [31:0] estimate_variance;
        logic               bad_step;
    } wakf_out_t;

    // configuration register indexes
    localparam logic [1:0] CFG_PROCESS_NOISE   = 2'd0;
    localparam logic [1:0] CFG_MEAS_NOISE      = 2'd1;
    localparam logic [1:0] CFG_INIT_UNCERT     = 2'd2;
    localparam logic [1:0] CFG_MAX_TIME_STEP   = 2'd3;

    localparam logic [31:0] RST_PROCESS_NOISE  = 32'd1677722;
    localparam logic [31:0] RST_MEAS_NOISE     = 32'd167772;
    localparam logic [31:0] RST_INIT_UNCERT    = 32'd16777216;
    localparam logic [23:0] RST_MAX_TIME_STEP  = 24'd104858;

    // quotient bits of the gain divide (gain can reach 2^16 before clamp)
    localparam int          DIV_STEPS          = 17;
    localparam logic [4:0]  DIV_STEPS_W        = 5'(DIV_STEPS);

    localparam logic [31:0] VAR_MAX            = 32'hFFFF_FFFF;
    localparam logic [15:0] GAIN_MAX           = 16'hFFFF;

    typedef enum logic [3:0] {
        S_IDLE,
        S_GROW,
        S_PRED,
        S_DEN,
        S_DIV,
        S_CORR,
        S_ANG,
        S_VAR,
        S_DONE
    } wakf_state_t;

endpackage

>>> hdl/wakf_mul.sv
// ----------------------------------------------------------------------------
// wakf_mul
// Shared 32x32 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module wakf_mul (
    input  logic        clk,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [63:0] product
);

    logic [63:0] product_reg;

    always_ff @(posedge clk)
    begin
        product_reg <= {32'd0, a} * {32'd0, b};
    end

    assign product = product_reg;

endmodule

>>> hdl/wakf_div.sv
// ----------------------------------------------------------------------------
// wakf_div
// Restoring divider, one quotient bit per cycle: (ppred << 16) / denom.
// ----------------------------------------------------------------------------
module wakf_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] ppred,
    input  logic [32:0] denom,
    output logic        busy,
    output logic        done,
    output logic [16:0] quotient
);

    logic        busy_reg,  busy_next;
    logic        done_reg,  done_next;
    logic [4:0]  cnt_reg,   cnt_next;
    logic [33:0] rem_reg,   rem_next;
    logic [16:0] low_reg,   low_next;
    logic [16:0] quo_reg,   quo_next;
    logic [32:0] den_reg,   den_next;

    logic [33:0] shifted;
    logic [33:0] diff;
    logic        ge;

    always_comb
    begin
        shifted = {rem_reg[32:0], low_reg[16]};
        diff    = shifted - {1'b0, den_reg};
        ge      = (shifted >= {1'b0, den_reg});

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        low_next  = low_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;

        if (start)
        begin
            // top dividend bits are already below the divisor
            rem_next  = {3'd0, ppred[31:1]};
            low_next  = {ppred[0], 16'd0};
            quo_next  = '0;
            den_next  = denom;
            cnt_next  = wakf_pkg::DIV_STEPS_W;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff : shifted;
            quo_next = {quo_reg[15:0], ge};
            low_next = {low_reg[15:0], 1'b0};
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> hdl/wrapped_angle_kalman_filter.sv
// ----------------------------------------------------------------------------
// wrapped_angle_kalman_filter
// Scalar Kalman filter tracking a 16-bit binary angle on the circle.
// ----------------------------------------------------------------------------
// One request carries a measured angle and a time step; one result comes back
// per request with the filtered angle, its Q8.24 variance and a bad-step flag.
// A zero time step goes from the accept straight to S_DONE, as does the first
// good measurement after reset (which just loads the estimate). Every other
// request runs the full update through S_GROW, S_PRED, S_DEN, S_DIV, S_CORR,
// S_ANG and S_VAR: one multiply for the process noise growth, a 17-step
// restoring divide for the gain, then two more multiplies for the angle
// correction and the variance shrink. The divide is the longest phase.
// S_DONE loads the result register once it is free or is being emptied.
// in_ready is high only while the sequencer is idle; a finished result may
// sit in the output register while the next request is taken.
// Configuration is written through cfg_we/cfg_index/cfg_data, by the user
// only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module wrapped_angle_kalman_filter (
    input  logic                clk,
    input  logic                rst_n,

    input  logic                in_valid,
    output logic                in_ready,
    input  wakf_pkg::wakf_in_t  in_data,

    output logic                out_valid,
    input  logic                out_ready,
    output wakf_pkg::wakf_out_t out_data,

    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data
);

    // configuration registers
    logic [31:0] pnr_reg;
    logic [31:0] mnoise_reg;
    logic [31:0] init_unc_reg;
    logic [23:0] max_step_reg;

    // filter state
    wakf_pkg::wakf_state_t state_reg, state_next;
    logic        started_reg,  started_next;
    logic [15:0] angle_reg,    angle_next;
    logic [31:0] var_reg,      var_next;

    // per-request working registers
    logic [15:0] meas_reg,     meas_next;
    logic [23:0] step_reg,     step_next;
    logic        bad_reg,      bad_next;
    logic [31:0] ppred_reg,    ppred_next;
    logic [32:0] denom_reg,    denom_next;
    logic [15:0] gain_reg,     gain_next;

    // result register
    logic                out_valid_reg, out_valid_next;
    wakf_pkg::wakf_out_t out_data_reg,  out_data_next;

    // shared units
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;
    logic        div_start;
    logic        div_busy;
    logic        div_done;
    logic [16:0] div_quo;

    // datapath temporaries
    logic [23:0] step_clamped;
    logic [36:0] pred_sum;
    logic [15:0] innov;
    logic [16:0] gain_cmp;
    logic [33:0] corr_full;
    logic [33:0] corr_shift;

    wakf_mul u_mul (
        .clk     (clk),
        .a       (mul_a),
        .b       (mul_b),
        .product (mul_p)
    );

    wakf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .ppred    (ppred_reg),
        .denom    (denom_next),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pnr_reg      <= wakf_pkg::RST_PROCESS_NOISE;
            mnoise_reg   <= wakf_pkg::RST_MEAS_NOISE;
            init_unc_reg <= wakf_pkg::RST_INIT_UNCERT;
            max_step_reg <= wakf_pkg::RST_MAX_TIME_STEP;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                wakf_pkg::CFG_PROCESS_NOISE: pnr_reg      <= cfg_data;
                wakf_pkg::CFG_MEAS_NOISE:    mnoise_reg   <= cfg_data;
                wakf_pkg::CFG_INIT_UNCERT:   init_unc_reg <= cfg_data;
                wakf_pkg::CFG_MAX_TIME_STEP: max_step_reg <= cfg_data[23:0];
                default:                     pnr_reg      <= pnr_reg;
            endcase
        end
    end

    // datapath pieces
    always_comb
    begin
        step_clamped = (in_data.time_step < max_step_reg) ? in_data.time_step
                                                          : max_step_reg;
        // growth = pnr * step / 2^20, up to 36 bits
        pred_sum = {5'd0, var_reg} + {1'b0, mul_p[55:20]};
        // wrapped innovation falls out of 16-bit subtraction
        innov    = meas_reg - angle_reg;
        gain_cmp = 17'h1_0000 - {1'b0, gain_reg};
        // signed gain*innov from the unsigned product, plus rounding half
        corr_full = {2'd0, mul_p[31:0]}
                  - (innov[15] ? {2'd0, gain_reg, 16'd0} : 34'd0)
                  + 34'd32768;
        corr_shift = 34'($signed(corr_full) >>> 16);
    end

    // shared multiplier operand select
    always_comb
    begin
        unique case (state_reg)
            wakf_pkg::S_GROW:
            begin
                mul_a = pnr_reg;
                mul_b = {8'd0, step_reg};
            end
            wakf_pkg::S_CORR:
            begin
                mul_a = {16'd0, gain_reg};
                mul_b = {16'd0, innov};
            end
            wakf_pkg::S_ANG:
            begin
                mul_a = {15'd0, gain_cmp};
                mul_b = ppred_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        started_next   = started_reg;
        angle_next     = angle_reg;
        var_next       = var_reg;
        meas_next      = meas_reg;
        step_next      = step_reg;
        bad_next       = bad_reg;
        ppred_next     = ppred_reg;
        denom_next     = denom_reg;
        gain_next      = gain_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        div_start      = 1'b0;
        in_ready       = 1'b0;

        // result leaves the output register
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            wakf_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    meas_next = in_data.measured_angle;
                    step_next = step_clamped;
                    bad_next  = 1'b0;
                    if (in_data.time_step == 24'd0)
                    begin
                        bad_next   = 1'b1;
                        state_next = wakf_pkg::S_DONE;
                    end
                    else if (!started_reg)
                    begin
                        angle_next   = in_data.measured_angle;
                        var_next     = init_unc_reg;
                        started_next = 1'b1;
                        state_next   = wakf_pkg::S_DONE;
                    end
                    else
                    begin
                        state_next = wakf_pkg::S_GROW;
                    end
                end
            end
            wakf_pkg::S_GROW:
            begin
                state_next = wakf_pkg::S_PRED;
            end
            wakf_pkg::S_PRED:
            begin
                // saturate predicted variance at 32 bits
                ppred_next = (pred_sum[36:32] != 5'd0) ? wakf_pkg::VAR_MAX
                                                       : pred_sum[31:0];
                state_next = wakf_pkg::S_DEN;
            end
            wakf_pkg::S_DEN:
            begin
                denom_next = {1'b0, ppred_reg} + {1'b0, mnoise_reg};
                div_start  = 1'b1;
                state_next = wakf_pkg::S_DIV;
            end
            wakf_pkg::S_DIV:
            begin
                if (div_done)
                begin
                    if (denom_reg == 33'd0)
                        gain_next = 16'd0;
                    else if (div_quo[16])
                        gain_next = wakf_pkg::GAIN_MAX;
                    else
                        gain_next = div_quo[15:0];
                    state_next = wakf_pkg::S_CORR;
                end
            end
            wakf_pkg::S_CORR:
            begin
                state_next = wakf_pkg::S_ANG;
            end
            wakf_pkg::S_ANG:
            begin
                angle_next = angle_reg + corr_shift[15:0];
                state_next = wakf_pkg::S_VAR;
            end
            wakf_pkg::S_VAR:
            begin
                var_next   = mul_p[47:16];
                state_next = wakf_pkg::S_DONE;
            end
            wakf_pkg::S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next                  = 1'b1;
                    out_data_next.estimate_angle    = angle_reg;
                    out_data_next.estimate_variance = var_reg;
                    out_data_next.bad_step          = bad_reg;
                    state_next                      = wakf_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = wakf_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wakf_pkg::S_IDLE;
            started_reg   <= 1'b0;
            angle_reg     <= '0;
            var_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            started_reg   <= started_next;
            angle_reg     <= angle_next;
            var_reg       <= var_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        meas_reg     <= meas_next;
        step_reg     <= step_next;
        bad_reg      <= bad_next;
        ppred_reg    <= ppred_next;
        denom_reg    <= denom_next;
        gain_reg     <= gain_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // checks
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == wakf_pkg::S_DIV))
        else $error("divider finished outside the divide phase");

    a_div_idle_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !div_busy)
        else $error("divider busy while taking a new request");

    a_bad_step_short: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (in_data.time_step == 24'd0))
        |=> ((state_reg == wakf_pkg::S_DONE) && bad_reg && $stable(angle_reg)))
        else $error("zero time step did not go straight to result");

    a_started_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        started_reg |=> started_reg)
        else $error("started flag dropped");

endmodule
